@@ design/glob_wildcard_matcher_assert.svh @@
// assertion macros used by the matcher top
`ifndef GLOB_WILDCARD_MATCHER_ASSERT_SVH
`define GLOB_WILDCARD_MATCHER_ASSERT_SVH

// checked at every edge, reset included
`define GWM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

// checked only while out of reset
`define GWM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

@@ design/gwm_pkg.sv @@
package gwm_pkg;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_DATA   = 2'd1,
		OP_END    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] ANY_CHAR  = 8'h3F;
	localparam logic [7:0] UPPER_A   = 8'h41;
	localparam logic [7:0] UPPER_Z   = 8'h5A;
	localparam logic [7:0] CASE_BIT  = 8'h20;

	function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
		logic [7:0] r;
		r = c;
		if (en && c >= UPPER_A && c <= UPPER_Z) begin
			r = c | CASE_BIT;
		end
		return r;
	endfunction

endpackage

@@ design/glob_wildcard_matcher.sv @@
// Glob matcher: load a pattern with append words ('*' any run, '?' any one char),
// then stream a name one data word at a time; an end word returns matched and
// pattern_overflow and rearms for the next name, a clear word empties the pattern.
// Throughput is one word per cycle for every op while in_stall is low. An accepted word
// sits in an input register and is processed from there; an end word's verdict then
// is written to the result register. The per-cycle path is the star closure, a carry
// chain over PATTERN_MAX+1 positions, followed by one byte compare per position.
// in_stall rises only while an end word waits behind a stalled, full result register.
`include "glob_wildcard_matcher_assert.svh"

module glob_wildcard_matcher #(
	parameter int PATTERN_MAX = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          in_valid,
	output logic          in_stall,
	input  gwm_pkg::op_t  op,
	input  logic [7:0]    char_code,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          matched,
	output logic          pattern_overflow
);
	import gwm_pkg::*;

	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int IW = $clog2(PATTERN_MAX);
	localparam logic [PATTERN_MAX:0] REARM = (PATTERN_MAX + 1)'(1);

	logic                 case_insensitive_q;
	logic                 valid_s1;
	op_t                  op_s1;
	logic [7:0]           char_s1;
	logic [7:0]           pattern_store_q [PATTERN_MAX];
	logic [LW-1:0]        len_q;
	logic [PATTERN_MAX:0] active_q;
	logic                 overflow_q;
	logic                 out_valid_q;
	logic                 matched_q;
	logic                 overflow_out_q;
	logic [PATTERN_MAX:0] closed;
	logic [PATTERN_MAX:0] next_active;
	logic                 consume;
	logic                 full;
	logic                 in_take;

	assign consume  = valid_s1 && ((op_s1 != OP_END) || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !consume;
	assign in_take  = in_valid && !in_stall;
	assign full     = (len_q == LW'(PATTERN_MAX));

	gwm_nfa #(.N(PATTERN_MAX)) u_nfa (
		.fold_en     (case_insensitive_q),
		.ch          (char_s1),
		.store       (pattern_store_q),
		.len         (len_q),
		.active      (active_q),
		.closed      (closed),
		.next_active (next_active)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_insensitive_q <= 1'b1;
		end else if (cfg_we) begin
			case_insensitive_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1   <= op;
			char_s1 <= char_code;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && op_s1 == OP_APPEND && !full) begin
			pattern_store_q[len_q[IW-1:0]] <= char_s1;
		end
	end

	// matcher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			active_q   <= REARM;
			overflow_q <= 1'b0;
		end else if (consume) begin
			unique case (op_s1)
				OP_APPEND: begin
					if (full) begin
						overflow_q <= 1'b1;
					end else begin
						len_q <= len_q + LW'(1);
					end
				end
				OP_DATA: begin
					active_q <= next_active;
				end
				OP_END: begin
					active_q <= REARM;
				end
				OP_CLEAR: begin
					len_q      <= '0;
					overflow_q <= 1'b0;
					active_q   <= REARM;
				end
				default: begin
					active_q <= REARM;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && op_s1 == OP_END) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && op_s1 == OP_END) begin
			matched_q      <= closed[len_q] && !overflow_q;
			overflow_out_q <= overflow_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = overflow_out_q;

	`GWM_ASSERT(a_end_gives_word, (consume && op_s1 == OP_END) |=> out_valid, "end word lost")
	`GWM_ASSERT(a_no_match_on_ovf, out_valid |-> !(matched && pattern_overflow), "match with overflow")
	`GWM_ASSERT_ALWAYS(a_len_range, len_q <= LW'(PATTERN_MAX), "pattern length out of range")
	`GWM_ASSERT(a_active_in_len, (active_q >> len_q) <= REARM, "active position beyond pattern")
	`GWM_ASSERT(a_stall_needs_end, in_stall |-> (op_s1 == OP_END && out_valid_q), "spurious stall")

endmodule

@@ design/gwm_nfa.sv @@
module gwm_nfa #(
	parameter int N = 32
) (
	input  logic                       fold_en,
	input  logic [7:0]                 ch,
	input  logic [7:0]                 store [N],
	input  logic [$clog2(N+1)-1:0]     len,
	input  logic [N:0]                 active,
	output logic [N:0]                 closed,
	output logic [N:0]                 next_active
);
	import gwm_pkg::*;

	logic [N-1:0] inlen;
	logic [N-1:0] star;
	logic [N-1:0] hit;
	logic [N:0]   gen_x;
	logic [N:0]   gen_y;
	logic [N:0]   sum;
	logic [N:0]   carry;
	logic [7:0]   fc;

	assign fc = fold_char(ch, fold_en);

	for (genvar i = 0; i < N; i++) begin : g_pos
		assign inlen[i] = (int'(len) > i);
		assign star[i]  = inlen[i] && (store[i] == STAR_CHAR);
		assign hit[i]   = inlen[i] && !star[i] &&
			((store[i] == ANY_CHAR) || (fold_char(store[i], fold_en) == fc));
	end

	// star closure as a carry chain: carry into i+1 = star[i] & (active[i] | carry[i])
	assign gen_x = {1'b0, star};
	assign gen_y = gen_x & active;
	assign sum   = gen_x + gen_y;
	assign carry = sum ^ gen_x ^ gen_y;
	assign closed = active | carry;

	// stars hold their own position, other matches advance by one
	assign next_active = ({1'b0, closed[N-1:0] & star}) | ({closed[N-1:0] & hit, 1'b0});

endmodule

@@ sim/gwm_verdict_checker.sv @@
`timescale 1ns / 1ps

module gwm_verdict_checker #(
	parameter int PATTERN_MAX = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          in_valid,
	input  logic          in_stall,
	input  gwm_pkg::op_t  op,
	input  logic [7:0]    char_code,
	input  logic          out_valid,
	input  logic          out_stall,
	input  logic          matched,
	input  logic          pattern_overflow,
	output int            fail_count,
	output int            outstanding
);
	import gwm_pkg::*;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	verdict_t             verdict_q[$];
	logic [7:0]           pat_mem [PATTERN_MAX];
	int                   pat_len;
	logic [PATTERN_MAX:0] live_pos;
	logic                 pat_dropped;
	logic                 fold_on;
	int                   errs;

	function automatic logic [7:0] lower_if_on(input logic [7:0] c);
		if (fold_on && c >= UPPER_A && c <= UPPER_Z) begin
			return c + CASE_BIT;
		end
		return c;
	endfunction

	task automatic rearm_positions();
		live_pos = '0;
		live_pos[0] = 1'b1;
	endtask

	// ascending order lets a run of stars pass in one sweep
	task automatic expand_stars();
		for (int i = 0; i < pat_len; i++) begin
			if (live_pos[i] && pat_mem[i] == STAR_CHAR) begin
				live_pos[i + 1] = 1'b1;
			end
		end
	endtask

	task automatic absorb_word(input op_t o, input logic [7:0] c);
		logic [PATTERN_MAX:0] nxt;
		logic [7:0]           fc;
		verdict_t             v;
		case (o)
			OP_APPEND: begin
				if (pat_len < PATTERN_MAX) begin
					pat_mem[pat_len] = c;
					pat_len++;
				end else begin
					pat_dropped = 1'b1;
				end
			end
			OP_DATA: begin
				fc = lower_if_on(c);
				expand_stars();
				nxt = '0;
				for (int i = 0; i < pat_len; i++) begin
					if (live_pos[i]) begin
						if (pat_mem[i] == STAR_CHAR) begin
							nxt[i] = 1'b1;
						end else if (pat_mem[i] == ANY_CHAR || lower_if_on(pat_mem[i]) == fc) begin
							nxt[i + 1] = 1'b1;
						end
					end
				end
				live_pos = nxt;
			end
			OP_END: begin
				expand_stars();
				v.matched  = live_pos[pat_len] && !pat_dropped;
				v.overflow = pat_dropped;
				verdict_q = {verdict_q, v};
				rearm_positions();
			end
			default: begin
				pat_len = 0;
				pat_dropped = 1'b0;
				rearm_positions();
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			verdict_q.delete();
			pat_len = 0;
			pat_dropped = 1'b0;
			fold_on = 1'b1;
			errs = 0;
			rearm_positions();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				fold_on = cfg_wdata;
			end
			if (in_valid && !in_stall) begin
				absorb_word(op, char_code);
			end
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("unexpected result word: matched %0b, pattern_overflow %0b",
						matched, pattern_overflow);
					errs++;
				end else begin
					want = verdict_q.pop_front();
					if (matched !== want.matched) begin
						$error("matched: expected %0b, actual %0b", want.matched, matched);
						errs++;
					end
					if (pattern_overflow !== want.overflow) begin
						$error("pattern_overflow: expected %0b, actual %0b",
							want.overflow, pattern_overflow);
						errs++;
					end
				end
			end
			fail_count <= errs;
			outstanding <= verdict_q.size();
		end
	end

endmodule

@@ sim/tb_glob_wildcard_matcher.sv @@
`timescale 1ns / 1ps

module tb_glob_wildcard_matcher;
	import gwm_pkg::*;

	localparam int         PATTERN_MAX   = 32;
	localparam int         CYCLE_LIMIT   = 300000;
	localparam int         HOLD_CYCLES   = 250;
	localparam int         SETTLE_CYCLES = 4;
	localparam logic [7:0] LOWER_A       = 8'h61;
	localparam logic [7:0] LOWER_Z       = 8'h7A;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	op_t        in_op;
	logic [7:0] in_char;
	logic       out_valid;
	logic       out_stall;
	logic       matched;
	logic       pattern_overflow;
	int         fail_count;
	int         outstanding;

	int         words_sent;
	int         cycle_count;
	bit         calm;
	bit         hold_req;
	logic [7:0] pat_q[$];

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	glob_wildcard_matcher #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (in_op),
		.char_code        (in_char),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

	gwm_verdict_checker #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (in_op),
		.char_code        (in_char),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.matched          (matched),
		.pattern_overflow (pattern_overflow),
		.fail_count       (fail_count),
		.outstanding      (outstanding)
	);

	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// letters on both sides of the fold range plus its neighbors
	function automatic logic [7:0] name_char();
		case ($urandom_range(0, 13))
			0:       return 8'h61;
			1:       return 8'h41;
			2:       return 8'h62;
			3:       return 8'h42;
			4:       return 8'h7A;
			5:       return 8'h5A;
			6:       return 8'h40;
			7:       return 8'h5B;
			8:       return 8'h60;
			9:       return 8'h7B;
			10:      return 8'h00;
			11:      return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pattern_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return STAR_CHAR;
		if (r < 25) return ANY_CHAR;
		return name_char();
	endfunction

	task automatic send_word(input op_t o, input logic [7:0] c);
		int n;
		in_valid <= 1'b1;
		in_op <= o;
		in_char <= c;
		do @(posedge clk); while (in_stall);
		words_sent++;
		n = pick_gap();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// quiet the input and let every verdict drain before touching the register
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_fold(input logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic build_pattern(input int len);
		logic [7:0] c;
		send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
		pat_q.delete();
		repeat (len) begin
			c = pattern_char();
			send_word(OP_APPEND, c);
			pat_q = {pat_q, c};
		end
	endtask

	// a faithful name follows the pattern, with case flips and the odd dropped char
	task automatic send_name(input bit faithful);
		logic [7:0] c;
		if (faithful) begin
			foreach (pat_q[i]) begin
				if ($urandom_range(0, 19) == 0) continue;
				if (pat_q[i] == STAR_CHAR) begin
					repeat ($urandom_range(0, 3)) send_word(OP_DATA, name_char());
				end else if (pat_q[i] == ANY_CHAR) begin
					send_word(OP_DATA, name_char());
				end else begin
					c = pat_q[i];
					if ((c | CASE_BIT) >= LOWER_A && (c | CASE_BIT) <= LOWER_Z
						&& $urandom_range(0, 1) == 1) begin
						c = c ^ CASE_BIT;
					end
					send_word(OP_DATA, c);
				end
			end
		end else begin
			repeat ($urandom_range(0, 6)) send_word(OP_DATA, name_char());
		end
		send_word(OP_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic random_phase(input logic fold, input int n_words);
		int stop;
		int len;
		settle();
		set_fold(fold);
		stop = words_sent + n_words;
		while (words_sent < stop) begin
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 9) < 7) begin
					len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
						: $urandom_range(28, 36);
					build_pattern(len);
				end
				repeat ($urandom_range(1, 3)) send_name($urandom_range(0, 3) != 0);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_word(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				end
			end
			calm = ($urandom_range(0, 9) == 0);
		end
		calm = 1'b0;
	endtask

	initial begin
		int n;
		bit held;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("glob_wildcard_matcher: mismatch");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid <= 1'b0;
		in_op <= OP_APPEND;
		in_char <= 8'h00;
		calm = 1'b0;
		hold_req = 1'b0;
		words_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern against empty and non-empty names
		send_word(OP_END, 8'h00);
		send_word(OP_DATA, 8'h00);
		send_word(OP_END, 8'hFF);
		// star, any, byte zero and folding in one pattern
		send_word(OP_APPEND, UPPER_A);
		send_word(OP_APPEND, STAR_CHAR);
		send_word(OP_APPEND, ANY_CHAR);
		send_word(OP_APPEND, 8'h00);
		send_word(OP_DATA, 8'h61);
		send_word(OP_DATA, 8'h58);
		send_word(OP_DATA, 8'hFF);
		send_word(OP_DATA, 8'h7A);
		send_word(OP_DATA, 8'h00);
		send_word(OP_END, 8'h00);
		// pattern grows while a name is in flight
		send_word(OP_DATA, 8'h61);
		send_word(OP_APPEND, 8'h6B);
		send_word(OP_DATA, 8'h6D);
		send_word(OP_DATA, 8'h00);
		send_word(OP_DATA, 8'h4B);
		send_word(OP_END, 8'h00);
		send_word(OP_CLEAR, 8'hFF);
		send_word(OP_END, 8'h00);

		random_phase(1'b0, 260);
		random_phase(1'b1, 260);

		// result side blocked while the sender keeps pushing end words
		settle();
		calm = 1'b1;
		hold_req = 1'b1;
		build_pattern(2);
		repeat (30) send_name(1'b1);
		calm = 1'b0;

		random_phase(1'b0, 260);
		random_phase(1'($urandom_range(0, 1)), 260);
		random_phase(1'b1, 260);

		settle();
		if (fail_count == 0) begin
			$display("glob_wildcard_matcher: match");
		end else begin
			$display("glob_wildcard_matcher: mismatch");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/gwm_pkg.sv
design/gwm_nfa.sv
design/glob_wildcard_matcher.sv
sim/gwm_verdict_checker.sv
sim/tb_glob_wildcard_matcher.sv
